// ===== src/tld_pkg.sv =====
// tld_pkg: shared types and constants of the terminal line discipline
// used by tld_ctrl, tld_datapath and terminal_line_discipline
package tld_pkg;

  localparam int OP_W      = 3;
  localparam int TERM_W    = 2;
  localparam int BYTE_W    = 8;
  localparam int CHAR_W    = 7;
  localparam int ECHO_W    = 3;
  localparam int S_TDATA_W = 8;
  localparam int S_TUSER_W = 5;
  localparam int M_TDATA_W = 24;

  localparam logic [CHAR_W-1:0] CHAR_CR = 7'h0D;
  localparam logic [CHAR_W-1:0] CHAR_LF = 7'h0A;

  typedef enum logic [OP_W-1:0] {
    OP_RX    = 3'd0,
    OP_TXRDY = 3'd1,
    OP_POLL  = 3'd2,
    OP_PUSH  = 3'd3,
    OP_POP   = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_LF,
    ST_POPCAP,
    ST_CHKIDLE,
    ST_SEND,
    ST_SENDCAP,
    ST_SEND2,
    ST_SENDCAP2,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    SRC_NONE,
    SRC_ECHO,
    SRC_OUT
  } src_t;

  typedef struct packed {
    logic latch;
    logic rx_push;
    logic lf_push;
    logic push_out;
    logic pop_rd;
    logic pop_cap;
    logic send_rd;
    logic send_cap;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic item_ok;
    logic is_cr;
    logic idle_now;
    logic retry;
    logic out_busy;
  } status_t;

endpackage

// ===== src/tld_ram.sv =====
// tld_ram: generic single write port, single read port ram
// registered read data, no dependencies
module tld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 96
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/tld_ctrl.sv =====
// tld_ctrl: sequencer that steps one request through queue actions and send attempts
// depends on tld_pkg
module tld_ctrl
  import tld_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.latch  = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (!status.item_ok) begin
          state_next = ST_DONE;
        end else begin
          case (status.op)
            OP_RX: begin
              cmd.rx_push = 1'b1;
              state_next  = status.is_cr ? ST_LF : ST_CHKIDLE;
            end
            OP_TXRDY, OP_POLL: begin
              state_next = ST_SEND;
            end
            OP_PUSH: begin
              cmd.push_out = 1'b1;
              state_next   = ST_CHKIDLE;
            end
            OP_POP: begin
              cmd.pop_rd = 1'b1;
              state_next = ST_POPCAP;
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase
        end
      end
      ST_LF: begin
        cmd.lf_push = 1'b1;
        state_next  = ST_CHKIDLE;
      end
      ST_POPCAP: begin
        cmd.pop_cap = 1'b1;
        state_next  = ST_CHKIDLE;
      end
      ST_CHKIDLE: begin
        state_next = status.idle_now ? ST_SEND : ST_DONE;
      end
      ST_SEND: begin
        cmd.send_rd = 1'b1;
        state_next  = ST_SENDCAP;
      end
      ST_SENDCAP: begin
        cmd.send_cap = 1'b1;
        if (status.op == OP_TXRDY && status.retry) begin
          state_next = ST_SEND2;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_SEND2: begin
        cmd.send_rd = 1'b1;
        state_next  = ST_SENDCAP2;
      end
      ST_SENDCAP2: begin
        cmd.send_cap = 1'b1;
        state_next   = ST_DONE;
      end
      ST_DONE: begin
        if (!status.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/tld_datapath.sv =====
// tld_datapath: per-terminal queue pointers, idle flags, queue rams and result register
// depends on tld_pkg and tld_ram
module tld_datapath
  import tld_pkg::*;
#(
  parameter int NUM_TERMINALS = 3,
  parameter int QUEUE_DEPTH   = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic [S_TUSER_W-1:0] s_tuser,
  input  logic                 cfg_wr_en,
  input  logic [ECHO_W-1:0]    cfg_wr_data,
  input  cmd_t                 cmd,
  output status_t              status,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata
);

  localparam int PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int RAM_DEPTH = NUM_TERMINALS * QUEUE_DEPTH;
  localparam int ADDR_W    = $clog2(RAM_DEPTH);
  localparam int TI_W      = (NUM_TERMINALS > 1) ? $clog2(NUM_TERMINALS) : 1;

  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] h,
                                                input logic [CNT_W-1:0] c);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(h) + (CNT_W+1)'(c);
    if (s >= (CNT_W+1)'(QUEUE_DEPTH)) begin
      s = s - (CNT_W+1)'(QUEUE_DEPTH);
    end
    return PTR_W'(s);
  endfunction

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] h);
    return (h == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : h + 1'b1;
  endfunction

  // item registers
  op_t               op_q;
  logic [TERM_W-1:0] term_q;
  logic [BYTE_W-1:0] data_q;
  logic [ECHO_W-1:0] echo_en;

  // per-terminal queue state
  logic [PTR_W-1:0] in_head  [NUM_TERMINALS];
  logic [CNT_W-1:0] in_cnt   [NUM_TERMINALS];
  logic [PTR_W-1:0] ec_head  [NUM_TERMINALS];
  logic [CNT_W-1:0] ec_cnt   [NUM_TERMINALS];
  logic [PTR_W-1:0] out_head [NUM_TERMINALS];
  logic [CNT_W-1:0] out_cnt  [NUM_TERMINALS];
  logic             idle     [NUM_TERMINALS];

  // result accumulation
  logic              r_tx_valid, r_in_post, r_out_post, r_rd_valid, r_dropped;
  logic [CHAR_W-1:0] r_tx_byte, r_rd_byte;
  src_t              src;

  logic [TI_W-1:0]   t_idx;
  logic [ADDR_W-1:0] t_base;
  logic [CHAR_W-1:0] ch;
  logic [ECHO_W:0]   echo_ext;
  logic              echo_on;
  logic              in_full, ec_full, out_full;
  logic              ec_we, in_we, out_we;
  logic              send_echo, send_out;
  logic [CHAR_W-1:0] in_rdata, ec_rdata;
  logic [BYTE_W-1:0] out_rdata;
  logic              ch_nz;

  assign t_idx    = TI_W'(term_q);
  assign t_base   = ADDR_W'(t_idx) * ADDR_W'(QUEUE_DEPTH);
  assign ch       = data_q[CHAR_W-1:0];
  assign echo_ext = {1'b0, echo_en};
  assign echo_on  = echo_ext[term_q];

  assign in_full  = (in_cnt[t_idx] == CNT_W'(QUEUE_DEPTH));
  assign ec_full  = (ec_cnt[t_idx] == CNT_W'(QUEUE_DEPTH));
  assign out_full = (out_cnt[t_idx] == CNT_W'(QUEUE_DEPTH));

  assign in_we  = cmd.rx_push && !in_full;
  assign ec_we  = ((cmd.rx_push && (status.is_cr || echo_on)) || cmd.lf_push) && !ec_full;
  assign out_we = cmd.push_out && !out_full;

  assign send_echo = cmd.send_rd && (ec_cnt[t_idx] != '0);
  assign send_out  = cmd.send_rd && (ec_cnt[t_idx] == '0) && (out_cnt[t_idx] != '0);

  always_comb begin
    ch_nz = 1'b0;
    case (src)
      SRC_ECHO: ch_nz = (ec_rdata != '0);
      SRC_OUT:  ch_nz = (out_rdata != '0);
      default:  ch_nz = 1'b0;
    endcase
  end

  assign status.op       = op_q;
  assign status.item_ok  = (op_q <= OP_POP) && (32'(term_q) < NUM_TERMINALS);
  assign status.is_cr    = (ch == CHAR_CR);
  assign status.idle_now = idle[t_idx];
  assign status.retry    = (src != SRC_OUT) && !ch_nz;
  assign status.out_busy = m_tvalid && !m_tready;

  tld_ram #(.WIDTH(CHAR_W), .DEPTH(RAM_DEPTH)) u_in_ram (
    .clk     (clk),
    .wr_en   (in_we),
    .wr_addr (t_base + ADDR_W'(wrap_add(in_head[t_idx], in_cnt[t_idx]))),
    .wr_data (ch),
    .rd_en   (cmd.pop_rd),
    .rd_addr (t_base + ADDR_W'(in_head[t_idx])),
    .rd_data (in_rdata)
  );

  tld_ram #(.WIDTH(CHAR_W), .DEPTH(RAM_DEPTH)) u_echo_ram (
    .clk     (clk),
    .wr_en   (ec_we),
    .wr_addr (t_base + ADDR_W'(wrap_add(ec_head[t_idx], ec_cnt[t_idx]))),
    .wr_data (cmd.lf_push ? CHAR_LF : ch),
    .rd_en   (send_echo),
    .rd_addr (t_base + ADDR_W'(ec_head[t_idx])),
    .rd_data (ec_rdata)
  );

  tld_ram #(.WIDTH(BYTE_W), .DEPTH(RAM_DEPTH)) u_out_ram (
    .clk     (clk),
    .wr_en   (out_we),
    .wr_addr (t_base + ADDR_W'(wrap_add(out_head[t_idx], out_cnt[t_idx]))),
    .wr_data (data_q),
    .rd_en   (send_out),
    .rd_addr (t_base + ADDR_W'(out_head[t_idx])),
    .rd_data (out_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q   <= op_t'(s_tuser[OP_W-1:0]);
      term_q <= s_tuser[OP_W +: TERM_W];
      data_q <= s_tdata[BYTE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      echo_en <= '0;
    end else if (cfg_wr_en) begin
      echo_en <= cfg_wr_data;
    end
  end

  // queue pointers and idle flags
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TERMINALS; i++) begin
        in_head[i]  <= '0;
        in_cnt[i]   <= '0;
        ec_head[i]  <= '0;
        ec_cnt[i]   <= '0;
        out_head[i] <= '0;
        out_cnt[i]  <= '0;
        idle[i]     <= 1'b1;
      end
    end else begin
      if (in_we) begin
        in_cnt[t_idx] <= in_cnt[t_idx] + 1'b1;
      end
      if (cmd.pop_rd && in_cnt[t_idx] != '0) begin
        in_head[t_idx] <= next_ptr(in_head[t_idx]);
        in_cnt[t_idx]  <= in_cnt[t_idx] - 1'b1;
      end
      if (ec_we) begin
        ec_cnt[t_idx] <= ec_cnt[t_idx] + 1'b1;
      end
      if (send_echo) begin
        ec_head[t_idx] <= next_ptr(ec_head[t_idx]);
        ec_cnt[t_idx]  <= ec_cnt[t_idx] - 1'b1;
      end
      if (out_we) begin
        out_cnt[t_idx] <= out_cnt[t_idx] + 1'b1;
      end
      if (send_out) begin
        out_head[t_idx] <= next_ptr(out_head[t_idx]);
        out_cnt[t_idx]  <= out_cnt[t_idx] - 1'b1;
      end
      if (cmd.send_cap) begin
        idle[t_idx] <= !ch_nz;
      end
    end
  end

  // result accumulation
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      r_tx_valid <= 1'b0;
      r_tx_byte  <= '0;
      r_in_post  <= 1'b0;
      r_out_post <= 1'b0;
      r_rd_valid <= 1'b0;
      r_rd_byte  <= '0;
      r_dropped  <= 1'b0;
      src        <= SRC_NONE;
    end else begin
      if (cmd.rx_push) begin
        r_in_post <= !in_full;
        if (in_full || (ec_full && (status.is_cr || echo_on))) begin
          r_dropped <= 1'b1;
        end
      end
      if ((cmd.lf_push && ec_full) || (cmd.push_out && out_full)) begin
        r_dropped <= 1'b1;
      end
      if (cmd.pop_rd && in_cnt[t_idx] != '0) begin
        r_rd_valid <= 1'b1;
      end
      if (cmd.pop_cap && r_rd_valid) begin
        r_rd_byte <= in_rdata;
      end
      if (cmd.send_rd) begin
        src <= send_echo ? SRC_ECHO : (send_out ? SRC_OUT : SRC_NONE);
      end
      if (cmd.send_cap) begin
        if (src == SRC_OUT) begin
          r_out_post <= 1'b1;
        end
        if (ch_nz) begin
          r_tx_valid <= 1'b1;
          r_tx_byte  <= (src == SRC_OUT) ? out_rdata[CHAR_W-1:0] : ec_rdata;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {5'b0, r_dropped, r_rd_byte, r_rd_valid, r_out_post, r_in_post,
                  r_tx_byte, r_tx_valid};
    end
  end

endmodule

// ===== src/terminal_line_discipline.sv =====
// terminal_line_discipline: top level, echo and queue handling for uart terminals
// depends on tld_pkg, tld_ctrl, tld_datapath, tld_ram
//
// channel   dir  signals                    contents
// request   in   s_tvalid s_tready          s_tuser, s_tdata
// result    out  m_tvalid m_tready          m_tdata
// config    in   cfg_wr_en                  cfg_wr_data (echo_enable)
//
// one request at a time: the sequencer steps through the queue writes and the registered
// ram reads of each send attempt, and the next request can be accepted in the cycle after
// the result is loaded
// a waiting result does not block the next request until its own result is due
// rst is synchronous: queues empty, all terminals idle, echo off
// a stalled result holds m_tdata and the sequencer waits at its last step
module terminal_line_discipline
  import tld_pkg::*;
#(
  parameter int NUM_TERMINALS = 3,
  parameter int QUEUE_DEPTH   = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // data_byte
  input  logic [S_TUSER_W-1:0] s_tuser,   // operation, terminal
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // tx_valid, tx_byte, input_post,
                                          // output_post, read_valid, read_byte,
                                          // dropped, zero fill
  input  logic                 cfg_wr_en,
  input  logic [ECHO_W-1:0]    cfg_wr_data
);

  cmd_t    cmd;
  status_t status;

  tld_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  tld_datapath #(
    .NUM_TERMINALS (NUM_TERMINALS),
    .QUEUE_DEPTH   (QUEUE_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .status      (status),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

endmodule
